FILE: hw/rtl/rfb_pkg.sv
// shared types, codes and helpers of the rgb332 frame store engine
// no dependencies; used by every rtl file of the block but the ram
`default_nettype none

package rfb_pkg;

  // default store geometry
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  // field widths
  localparam int CMD_W   = 2;
  localparam int POS_W   = 12;
  localparam int COORD_W = 10;
  localparam int BOX_W   = 9;
  localparam int OFF_W   = 9;
  localparam int BYTE_W  = 8;
  localparam int RGB_W   = 24;
  localparam int PROD_W  = 2 * COORD_W;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET = 2'd2;

  localparam logic [COORD_W-1:0] RESET_WIDTH  = 10'd480;
  localparam logic [COORD_W-1:0] RESET_HEIGHT = 10'd320;
  localparam logic [OFF_W-1:0]   RESET_OFFSET = 9'd0;

  // command codes
  localparam logic [CMD_W-1:0] CMD_FILL    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COLLECT = 2'd3;

  // rgb332 expansion masks
  localparam logic [BYTE_W-1:0] RED_MASK   = 8'b11100000;
  localparam logic [BYTE_W-1:0] GREEN_MASK = 8'b00011100;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [POS_W-1:0] x_first;
    logic signed [POS_W-1:0] y_first;
    logic signed [POS_W-1:0] x_second;
    logic signed [POS_W-1:0] y_second;
    logic [RGB_W-1:0]        fill_colour;
    logic [BYTE_W-1:0]       pixel_byte;
  } rfb_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic [BYTE_W-1:0] red_out;
    logic [BYTE_W-1:0] green_out;
    logic [BYTE_W-1:0] blue_out;
    logic              box_valid;
    logic [BOX_W-1:0]  box_x_low;
    logic [BOX_W-1:0]  box_y_low;
    logic [BOX_W-1:0]  box_x_high;
    logic [BOX_W-1:0]  box_y_high;
    logic              dropped;
  } rfb_out_t;

  // classified command as it sits in the queue
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] x_lo;
    logic [COORD_W-1:0] y_lo;
    logic [COORD_W-1:0] x_hi;
    logic [COORD_W-1:0] y_hi;
    logic [BYTE_W-1:0]  data;
    logic               dropped;
  } rfb_op_t;

  // clamp a signed coordinate into 0 .. hi
  function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [POS_W-1:0] v,
                                                     input logic [COORD_W-1:0] hi);
    logic signed [POS_W:0] hi_s;
    hi_s = $signed({{(POS_W + 1 - COORD_W){1'b0}}, hi});
    if (v[POS_W-1]) return '0;
    else if ($signed({v[POS_W-1], v}) > hi_s) return hi;
    else return v[COORD_W-1:0];
  endfunction

  // size register as it acts: zero reads as one, capped at the store limit
  function automatic logic [COORD_W-1:0] eff_size(input logic [COORD_W-1:0] v,
                                                  input int unsigned lim);
    if (v == '0) return COORD_W'(1);
    else if (int'(v) > lim) return COORD_W'(lim);
    else return v;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rfb_ram.sv
// generic single port ram with registered read
// no dependencies
`default_nettype none

module rfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/rfb_front.sv
// front end: takes input beats and classifies them into queue entries
// depends on rfb_pkg
`default_nettype none

module rfb_front (
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire rfb_pkg::rfb_in_t               in_data,
  input  wire logic [rfb_pkg::COORD_W-1:0]    eff_w,
  input  wire logic [rfb_pkg::COORD_W-1:0]    eff_h,
  input  wire logic                           cfg_busy,
  input  wire logic                           q_full,
  output logic                                q_push,
  output rfb_pkg::rfb_op_t                    q_data
);

  logic [rfb_pkg::COORD_W-1:0] w_max, h_max;
  logic signed [rfb_pkg::POS_W-1:0] x_lo_raw, x_hi_raw, y_lo_raw, y_hi_raw;
  logic [rfb_pkg::COORD_W-1:0] x_pix, y_pix;
  logic x_in, y_in;

  assign w_max = eff_w - 1'b1;
  assign h_max = eff_h - 1'b1;

  // order the fill corners
  always_comb begin
    if ($signed(in_data.x_second) <= $signed(in_data.x_first)) begin
      x_lo_raw = in_data.x_second;
      x_hi_raw = in_data.x_first;
    end else begin
      x_lo_raw = in_data.x_first;
      x_hi_raw = in_data.x_second;
    end
    if ($signed(in_data.y_second) <= $signed(in_data.y_first)) begin
      y_lo_raw = in_data.y_second;
      y_hi_raw = in_data.y_first;
    end else begin
      y_lo_raw = in_data.y_first;
      y_hi_raw = in_data.y_second;
    end
  end

  assign x_pix = rfb_pkg::clamp_coord(in_data.x_first, w_max);
  assign y_pix = rfb_pkg::clamp_coord(in_data.y_first, h_max);

  // on-screen test for pixel writes
  assign x_in = !in_data.x_first[rfb_pkg::POS_W-1] &&
                (in_data.x_first[rfb_pkg::POS_W-2:0] < (rfb_pkg::POS_W-1)'(eff_w));
  assign y_in = !in_data.y_first[rfb_pkg::POS_W-1] &&
                (in_data.y_first[rfb_pkg::POS_W-2:0] < (rfb_pkg::POS_W-1)'(eff_h));

  always_comb begin
    q_data     = '0;
    q_data.cmd = in_data.cmd;
    unique case (in_data.cmd)
      rfb_pkg::CMD_FILL: begin
        q_data.x_lo = rfb_pkg::clamp_coord(x_lo_raw, w_max);
        q_data.x_hi = rfb_pkg::clamp_coord(x_hi_raw, w_max);
        q_data.y_lo = rfb_pkg::clamp_coord(y_lo_raw, h_max);
        q_data.y_hi = rfb_pkg::clamp_coord(y_hi_raw, h_max);
        // rgb888 reduced to rgb332
        q_data.data = {in_data.fill_colour[23:21], in_data.fill_colour[15:13],
                       in_data.fill_colour[7:6]};
      end
      rfb_pkg::CMD_WRITE: begin
        q_data.x_lo    = x_pix;
        q_data.x_hi    = x_pix;
        q_data.y_lo    = y_pix;
        q_data.y_hi    = y_pix;
        q_data.data    = in_data.pixel_byte;
        q_data.dropped = !(x_in && y_in);
      end
      rfb_pkg::CMD_READ: begin
        q_data.x_lo = x_pix;
        q_data.x_hi = x_pix;
        q_data.y_lo = y_pix;
        q_data.y_hi = y_pix;
      end
      rfb_pkg::CMD_COLLECT: begin
        q_data.dropped = 1'b0;
      end
    endcase
  end

  assign in_ready = !q_full && !cfg_busy;
  assign q_push   = in_valid && in_ready;

endmodule

`default_nettype wire

FILE: hw/rtl/rfb_queue.sv
// short queue of classified commands between front and back
// depends on rfb_pkg
`default_nettype none

module rfb_queue #(
  parameter int DEPTH = rfb_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rfb_pkg::rfb_op_t  push_data,
  output logic                   full,
  input  wire logic              pop,
  output rfb_pkg::rfb_op_t       pop_data,
  output logic                   empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rfb_pkg::rfb_op_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/rfb_back.sv
// back end: runs queued commands against the frame store, keeps the dirty box
// depends on rfb_pkg and rfb_ram
`default_nettype none

module rfb_back #(
  parameter int MAX_WIDTH  = rfb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rfb_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_empty,
  input  wire rfb_pkg::rfb_op_t             q_data,
  output logic                              q_pop,
  input  wire logic [rfb_pkg::COORD_W-1:0]  eff_w,
  input  wire logic [rfb_pkg::COORD_W-1:0]  eff_h,
  input  wire logic [rfb_pkg::COORD_W-1:0]  off_mod,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output rfb_pkg::rfb_out_t                 out_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = rfb_pkg::COORD_W;
  localparam int BW    = rfb_pkg::BOX_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [rfb_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [CW-1:0] xl_r, xl_nxt, xh_r, xh_nxt, yh_r, yh_nxt;
  logic [CW-1:0] x_cnt_r, x_cnt_nxt, y_cnt_r, y_cnt_nxt;
  logic [rfb_pkg::BYTE_W-1:0] byte_r, byte_nxt;

  logic dv_r, dv_nxt;
  logic [BW-1:0] dl_r, dl_nxt, dt_r, dt_nxt, dr_r, dr_nxt, db_r, db_nxt;
  logic [BW-1:0] gl, gt, gr, gb;

  logic out_valid_r, out_valid_nxt;
  rfb_pkg::rfb_out_t out_data_r, out_data_nxt;

  // address path: row wrap, multiply, add
  logic v1_r, last1_r, v2_r, last2_r, v3_r;
  logic [CW-1:0] x1_r, row1_r, x2_r;
  logic [rfb_pkg::PROD_W-1:0] prod2_r;
  logic [CW:0] row_sum;
  logic [CW-1:0] row;

  logic out_free, issue, x_last, y_last, issue_last, wr_done, rd_done;
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [rfb_pkg::BYTE_W-1:0] ram_rdata;

  assign out_free   = !out_valid_r || out_ready;
  assign q_pop      = (state_r == ST_IDLE) && !q_empty && out_free;
  assign issue      = (state_r == ST_RUN);
  assign x_last     = (x_cnt_r == xh_r);
  assign y_last     = (y_cnt_r == yh_r);
  assign issue_last = x_last && y_last;

  // circular row mapping, both terms already below the height
  assign row_sum = {1'b0, y_cnt_r} + {1'b0, off_mod};
  assign row     = (row_sum >= {1'b0, eff_h}) ? CW'(row_sum - {1'b0, eff_h})
                                              : row_sum[CW-1:0];

  assign ram_addr = AW'(prod2_r + rfb_pkg::PROD_W'(x2_r));
  assign ram_we   = v2_r && (cmd_r != rfb_pkg::CMD_READ);
  assign wr_done  = v2_r && last2_r && (cmd_r != rfb_pkg::CMD_READ);
  assign rd_done  = v3_r;

  assign gl = q_data.x_lo[BW-1:0];
  assign gt = q_data.y_lo[BW-1:0];
  assign gr = q_data.x_hi[BW-1:0];
  assign gb = q_data.y_hi[BW-1:0];

  rfb_ram #(
    .WIDTH (rfb_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (byte_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    xl_nxt        = xl_r;
    xh_nxt        = xh_r;
    yh_nxt        = yh_r;
    x_cnt_nxt     = x_cnt_r;
    y_cnt_nxt     = y_cnt_r;
    byte_nxt      = byte_r;
    dv_nxt        = dv_r;
    dl_nxt        = dl_r;
    dt_nxt        = dt_r;
    dr_nxt        = dr_r;
    db_nxt        = db_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          cmd_nxt   = q_data.cmd;
          xl_nxt    = q_data.x_lo;
          xh_nxt    = q_data.x_hi;
          yh_nxt    = q_data.y_hi;
          x_cnt_nxt = q_data.x_lo;
          y_cnt_nxt = q_data.y_lo;
          byte_nxt  = q_data.data;
          if (q_data.cmd == rfb_pkg::CMD_COLLECT) begin
            // report and empty the box
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            if (dv_r) begin
              out_data_nxt.box_valid  = 1'b1;
              out_data_nxt.box_x_low  = dl_r;
              out_data_nxt.box_y_low  = dt_r;
              out_data_nxt.box_x_high = dr_r;
              out_data_nxt.box_y_high = db_r;
            end
            dv_nxt = 1'b0;
            dl_nxt = '0;
            dt_nxt = '0;
            dr_nxt = '0;
            db_nxt = '0;
          end else if (q_data.dropped) begin
            // off-screen write: flag only
            out_valid_nxt        = 1'b1;
            out_data_nxt         = '0;
            out_data_nxt.dropped = 1'b1;
          end else begin
            dv_nxt = 1'b1;
            if (!dv_r) begin
              dl_nxt = gl;
              dt_nxt = gt;
              dr_nxt = gr;
              db_nxt = gb;
            end else begin
              if (gl < dl_r) dl_nxt = gl;
              if (gt < dt_r) dt_nxt = gt;
              if (gr > dr_r) dr_nxt = gr;
              if (gb > db_r) db_nxt = gb;
            end
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        // one pixel into the address path per cycle, row by row
        if (issue_last) begin
          state_nxt = ST_WAIT;
        end else if (x_last) begin
          x_cnt_nxt = xl_r;
          y_cnt_nxt = y_cnt_r + 1'b1;
        end else begin
          x_cnt_nxt = x_cnt_r + 1'b1;
        end
      end
      ST_WAIT: begin
        if (wr_done) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = ST_IDLE;
        end else if (rd_done) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt           = '0;
          out_data_nxt.read_byte = ram_rdata;
          out_data_nxt.red_out   = ram_rdata & rfb_pkg::RED_MASK;
          out_data_nxt.green_out = rfb_pkg::BYTE_W'((ram_rdata & rfb_pkg::GREEN_MASK) << 3);
          out_data_nxt.blue_out  = {ram_rdata[1:0], 6'b000000};
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    xl_r       <= xl_nxt;
    xh_r       <= xh_nxt;
    yh_r       <= yh_nxt;
    x_cnt_r    <= x_cnt_nxt;
    y_cnt_r    <= y_cnt_nxt;
    byte_r     <= byte_nxt;
    out_data_r <= out_data_nxt;
    x1_r       <= x_cnt_r;
    row1_r     <= row;
    last1_r    <= issue_last;
    x2_r       <= x1_r;
    prod2_r    <= rfb_pkg::PROD_W'(row1_r) * rfb_pkg::PROD_W'(eff_w);
    last2_r    <= last1_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      dv_r        <= 1'b0;
      dl_r        <= '0;
      dt_r        <= '0;
      dr_r        <= '0;
      db_r        <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dv_r        <= dv_nxt;
      dl_r        <= dl_nxt;
      dt_r        <= dt_nxt;
      dr_r        <= dr_nxt;
      db_r        <= db_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      v3_r        <= v2_r && last2_r && (cmd_r == rfb_pkg::CMD_READ);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_slot_free_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT && (wr_done || rd_done)) |-> !out_valid_r)
    else $error("command finished while the output register was still full");

  a_path_busy_only_in_op: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r || v2_r || v3_r) |-> (state_r != ST_IDLE))
    else $error("address path active with no command in flight");

  a_empty_box_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !dv_r |-> ((dl_r | dt_r | dr_r | db_r) == '0))
    else $error("empty dirty box holds non-zero edges");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/rgb332_framebuffer_engine_top.sv
// top level of the rgb332 shadow frame store with dirty box tracking
// depends on rfb_pkg, rfb_front, rfb_queue, rfb_back (and rfb_ram below it)
`default_nettype none

// usage
//   input channel in_valid/in_ready/in_data carries one command per beat: fill
//   rectangle, write pixel, read pixel or collect dirty box; each command gives
//   exactly one result beat on out_valid/out_ready/out_data, in command order
//   apb-style configuration port: screen width at 0x0, screen height at 0x4,
//   row offset at 0x8; pready is tied high
// timing
//   collect and off-screen writes: answered from the idle state of the back end,
//   with no trip through the address path
//   pixel write / read: a single pixel sent through the address path
//   fill: one store write per cycle
//   the rate is set by the back-end sequencer: one store port fed through an
//   address path (row wrap, row times width, add column)
//   a write to height or offset keeps in_ready low while the offset is reduced
//   modulo the height, one bit a cycle
// reset and stalls
//   registers return to 480 x 320, offset 0, dirty box empty; the store itself
//   is not cleared, so read only what has been written
//   a two-deep queue parts front from back; a held result stalls the back end
//   and, once the queue fills, in_ready drops

module rgb332_framebuffer_engine_top #(
  parameter int MAX_WIDTH  = rfb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rfb_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire rfb_pkg::rfb_in_t                   in_data,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output rfb_pkg::rfb_out_t                       out_data,
  // configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [rfb_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [rfb_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [rfb_pkg::CFG_DATA_W-1:0]          prdata,
  output logic                                    pready
);

  localparam int CW = rfb_pkg::COORD_W;
  localparam logic [3:0] OFF_MSB = 4'(rfb_pkg::OFF_W - 1);

  // configuration registers, raw and as they act
  logic [CW-1:0] width_r, height_r;
  logic [rfb_pkg::OFF_W-1:0] offset_r;
  logic [CW-1:0] eff_w_r, eff_h_r;

  logic cfg_wr;
  logic [rfb_pkg::REG_IDX_W-1:0] cfg_idx;
  logic restart_mod;

  // offset modulo height, restoring remainder one bit a cycle
  logic mod_busy_r;
  logic [3:0] mod_cnt_r;
  logic [CW-1:0] mod_rem_r, mod_rem_nxt;
  logic [CW:0] mod_trial;

  // front to queue to back
  logic q_push, q_pop, q_full, q_empty;
  rfb_pkg::rfb_op_t q_in, q_out;

  assign pready      = 1'b1;
  assign cfg_idx     = paddr[rfb_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign restart_mod = cfg_wr && ((cfg_idx == rfb_pkg::REG_HEIGHT) ||
                                  (cfg_idx == rfb_pkg::REG_OFFSET));

  always_comb begin
    unique case (cfg_idx)
      rfb_pkg::REG_WIDTH:  prdata = rfb_pkg::CFG_DATA_W'(width_r);
      rfb_pkg::REG_HEIGHT: prdata = rfb_pkg::CFG_DATA_W'(height_r);
      rfb_pkg::REG_OFFSET: prdata = rfb_pkg::CFG_DATA_W'(offset_r);
      default:             prdata = '0;
    endcase
  end

  // next remainder: shift in the next offset bit, subtract height if it fits
  assign mod_trial   = {mod_rem_r, offset_r[OFF_MSB - mod_cnt_r]};
  assign mod_rem_nxt = (mod_trial >= {1'b0, eff_h_r}) ? CW'(mod_trial - {1'b0, eff_h_r})
                                                      : mod_trial[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= rfb_pkg::RESET_WIDTH;
      height_r   <= rfb_pkg::RESET_HEIGHT;
      offset_r   <= rfb_pkg::RESET_OFFSET;
      eff_w_r    <= rfb_pkg::eff_size(rfb_pkg::RESET_WIDTH, MAX_WIDTH);
      eff_h_r    <= rfb_pkg::eff_size(rfb_pkg::RESET_HEIGHT, MAX_HEIGHT);
      mod_busy_r <= 1'b0;
      mod_cnt_r  <= '0;
      mod_rem_r  <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          rfb_pkg::REG_WIDTH: begin
            width_r <= pwdata[CW-1:0];
            eff_w_r <= rfb_pkg::eff_size(pwdata[CW-1:0], MAX_WIDTH);
          end
          rfb_pkg::REG_HEIGHT: begin
            height_r <= pwdata[CW-1:0];
            eff_h_r  <= rfb_pkg::eff_size(pwdata[CW-1:0], MAX_HEIGHT);
          end
          rfb_pkg::REG_OFFSET: begin
            offset_r <= pwdata[rfb_pkg::OFF_W-1:0];
          end
          default: begin
            // unmapped address, write ignored
            offset_r <= offset_r;
          end
        endcase
      end
      if (restart_mod) begin
        mod_busy_r <= 1'b1;
        mod_cnt_r  <= '0;
        mod_rem_r  <= '0;
      end else if (mod_busy_r) begin
        mod_rem_r <= mod_rem_nxt;
        mod_cnt_r <= mod_cnt_r + 1'b1;
        if (mod_cnt_r == OFF_MSB) begin
          mod_busy_r <= 1'b0;
        end
      end
    end
  end

  rfb_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .eff_w    (eff_w_r),
    .eff_h    (eff_h_r),
    .cfg_busy (mod_busy_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  rfb_queue #(
    .DEPTH (rfb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  rfb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .eff_w     (eff_w_r),
    .eff_h     (eff_h_r),
    .off_mod   (mod_rem_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_mod_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    restart_mod |=> (mod_busy_r && (mod_cnt_r == '0)))
    else $error("offset reduction did not restart after a height or offset write");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_rgb332_framebuffer_engine_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the rgb332 frame store engine: directed and random commands,
// a shadow store with dirty box, and apb geometry changes between phases
// depends on rfb_pkg and rgb332_framebuffer_engine_top
module tb_rgb332_framebuffer_engine_top;
  import rfb_pkg::*;

  localparam int STORE_PIX   = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int CYCLE_LIMIT = 3_000_000;
  // fills above this many pixels are drawn from a shared budget so the run stays short
  localparam int BIG_FILL    = 256;
  localparam int HOLD_CYCLES = 300;

  // dut ports, every input known from time zero
  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  rfb_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rfb_out_t out_data;
  logic     psel      = 1'b0;
  logic     penable   = 1'b0;
  logic     pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr  = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic     pready;

  rgb332_framebuffer_engine_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #4 clk = ~clk;

  // shadow of the block: pixel store, dirty box and geometry registers
  logic [BYTE_W-1:0] pix_mem [STORE_PIX];
  logic              box_live = 1'b0;
  logic [BOX_W-1:0]  box_l = '0, box_t = '0, box_r = '0, box_b = '0;
  logic [COORD_W-1:0] geo_w   = RESET_WIDTH;
  logic [COORD_W-1:0] geo_h   = RESET_HEIGHT;
  logic [OFF_W-1:0]   geo_off = RESET_OFFSET;

  // store addresses that some queued command is sure to have written before it is read
  bit planned_px [STORE_PIX];

  rfb_in_t  cmd_backlog[$];
  rfb_out_t pending_results[$];

  int  sent_cnt = 0, took_cnt = 0, seen_cnt = 0, err_cnt = 0, cycle_cnt = 0;
  int  big_budget = 350000;
  bit  calm = 1'b0;
  logic in_taken = 1'b0;

  // geometry as the block applies it: zero acts as one, capped at the store size
  function automatic int eff_w();
    return (geo_w == 0) ? 1 : (geo_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(geo_w);
  endfunction

  function automatic int eff_h();
    return (geo_h == 0) ? 1 : (geo_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(geo_h);
  endfunction

  function automatic int clip(int v, int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  function automatic int sx(logic [POS_W-1:0] v);
    return int'($signed(v));
  endfunction

  // screen row wraps through the offset, modulo the height
  function automatic int pix_addr(int x, int y);
    return ((y + int'(geo_off)) % eff_h()) * eff_w() + x;
  endfunction

  // corners put in order, then each clamped onto the screen
  function automatic void fill_rect(input rfb_in_t it, output int x0, output int y0,
                                    output int x1, output int y1);
    int t;
    x0 = sx(it.x_first);  y0 = sx(it.y_first);
    x1 = sx(it.x_second); y1 = sx(it.y_second);
    if (x1 < x0) begin
      t = x0; x0 = x1; x1 = t;
    end
    if (y1 < y0) begin
      t = y0; y0 = y1; y1 = t;
    end
    x0 = clip(x0, eff_w() - 1); x1 = clip(x1, eff_w() - 1);
    y0 = clip(y0, eff_h() - 1); y1 = clip(y1, eff_h() - 1);
  endfunction

  function automatic void grow_box(int l, int t, int r, int b);
    if (!box_live) begin
      box_l = BOX_W'(l); box_t = BOX_W'(t); box_r = BOX_W'(r); box_b = BOX_W'(b);
      box_live = 1'b1;
    end else begin
      if (l < box_l) box_l = BOX_W'(l);
      if (t < box_t) box_t = BOX_W'(t);
      if (r > box_r) box_r = BOX_W'(r);
      if (b > box_b) box_b = BOX_W'(b);
    end
  endfunction

  // result of one command, updating the shadow store and box
  function automatic rfb_out_t frame_result(rfb_in_t it);
    rfb_out_t res;
    int x0, y0, x1, y1;
    logic [BYTE_W-1:0] c;
    res = '0;
    case (it.cmd)
      CMD_FILL: begin
        c = {it.fill_colour[23:21], it.fill_colour[15:13], it.fill_colour[7:6]};
        fill_rect(it, x0, y0, x1, y1);
        grow_box(x0, y0, x1, y1);
        for (int y = y0; y <= y1; y++)
          for (int x = x0; x <= x1; x++)
            pix_mem[pix_addr(x, y)] = c;
      end
      CMD_WRITE: begin
        x0 = sx(it.x_first); y0 = sx(it.y_first);
        if (x0 >= 0 && x0 < eff_w() && y0 >= 0 && y0 < eff_h()) begin
          pix_mem[pix_addr(x0, y0)] = it.pixel_byte;
          grow_box(x0, y0, x0, y0);
        end else begin
          res.dropped = 1'b1;
        end
      end
      CMD_READ: begin
        x0 = clip(sx(it.x_first), eff_w() - 1);
        y0 = clip(sx(it.y_first), eff_h() - 1);
        grow_box(x0, y0, x0, y0);
        c = pix_mem[pix_addr(x0, y0)];
        res.read_byte = c;
        res.red_out   = c & RED_MASK;
        res.green_out = (c & GREEN_MASK) << 3;
        res.blue_out  = {c[1:0], 6'b0};
      end
      default: begin
        if (box_live) begin
          res.box_valid  = 1'b1;
          res.box_x_low  = box_l;
          res.box_y_low  = box_t;
          res.box_x_high = box_r;
          res.box_y_high = box_b;
        end
        box_live = 1'b0;
        box_l = '0; box_t = '0; box_r = '0; box_b = '0;
      end
    endcase
    return res;
  endfunction

  function automatic void check_field(string tag, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, tag, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  function automatic rfb_in_t raw_item();
    logic [95:0] bits_all;
    bits_all = {$urandom, $urandom, $urandom};
    return bits_all[$bits(rfb_in_t)-1:0];
  endfunction

  function automatic rfb_in_t mk_cmd(logic [CMD_W-1:0] c, int xa, int ya, int xb, int yb,
                                     logic [RGB_W-1:0] col, logic [BYTE_W-1:0] pb);
    rfb_in_t it;
    it = raw_item();
    it.cmd = c;
    it.x_first  = POS_W'(xa); it.y_first  = POS_W'(ya);
    it.x_second = POS_W'(xb); it.y_second = POS_W'(yb);
    it.fill_colour = col;
    it.pixel_byte  = pb;
    return it;
  endfunction

  // mostly on screen, sometimes on the border or anywhere in the signed range
  function automatic logic [POS_W-1:0] pick_pos(int lim);
    int r;
    r = $urandom_range(0, 7);
    if (r < 2) return POS_W'($urandom);
    if (r == 2) begin
      case ($urandom_range(0, 3))
        0: return POS_W'(-1);
        1: return '0;
        2: return POS_W'(lim - 1);
        default: return POS_W'(lim);
      endcase
    end
    return POS_W'($urandom_range(0, lim - 1));
  endfunction

  // queue a command and note which store entries it is bound to write
  task automatic queue_cmd(rfb_in_t it);
    int x0, y0, x1, y1;
    if (it.cmd == CMD_FILL) begin
      fill_rect(it, x0, y0, x1, y1);
      for (int y = y0; y <= y1; y++)
        for (int x = x0; x <= x1; x++)
          planned_px[pix_addr(x, y)] = 1'b1;
    end else if (it.cmd == CMD_WRITE) begin
      x0 = sx(it.x_first); y0 = sx(it.y_first);
      if (x0 >= 0 && x0 < eff_w() && y0 >= 0 && y0 < eff_h())
        planned_px[pix_addr(x0, y0)] = 1'b1;
    end
    cmd_backlog.push_back(it);
    sent_cnt++;
  endtask

  task automatic make_random();
    rfb_in_t it;
    int r, x0, y0, x1, y1, area, tries;
    it = raw_item();
    r  = $urandom_range(0, 99);
    if (r < 20) begin
      it.cmd = CMD_FILL;
      it.x_first = pick_pos(eff_w());
      it.y_first = pick_pos(eff_h());
      // mostly small rectangles near the first corner, now and then a wild second corner
      if ($urandom_range(0, 9) != 0) begin
        it.x_second = it.x_first + POS_W'(int'($urandom_range(0, 14)) - 7);
        it.y_second = it.y_first + POS_W'(int'($urandom_range(0, 14)) - 7);
      end
      fill_rect(it, x0, y0, x1, y1);
      area = (x1 - x0 + 1) * (y1 - y0 + 1);
      if (area > BIG_FILL) begin
        if (area <= big_budget) begin
          big_budget -= area;
        end else begin
          it.x_second = it.x_first;
          it.y_second = it.y_first;
        end
      end
    end else if (r < 55) begin
      it.cmd = CMD_WRITE;
      it.x_first = pick_pos(eff_w());
      it.y_first = pick_pos(eff_h());
    end else if (r < 85) begin
      // reads only land on entries already written
      it.cmd = CMD_READ;
      for (tries = 0; tries < 12; tries++) begin
        it.x_first = pick_pos(eff_w());
        it.y_first = pick_pos(eff_h());
        if (planned_px[pix_addr(clip(sx(it.x_first), eff_w() - 1),
                                clip(sx(it.y_first), eff_h() - 1))]) break;
      end
      if (tries == 12) begin
        it.x_first = POS_W'($urandom_range(0, (eff_w() < 8) ? eff_w() - 1 : 7));
        it.y_first = POS_W'($urandom_range(0, (eff_h() < 8) ? eff_h() - 1 : 7));
      end
    end else begin
      it.cmd = CMD_COLLECT;
    end
    queue_cmd(it);
  endtask

  // paint the four corners so clamped reads have something to hit
  task automatic seed_corners();
    int w, h;
    w = eff_w(); h = eff_h();
    for (int k = 0; k < 4; k++)
      queue_cmd(mk_cmd(CMD_FILL, (k % 2) ? w - 8 : 0, (k / 2) ? h - 8 : 0,
                       (k % 2) ? w - 1 : 7, (k / 2) ? h - 1 : 7,
                       RGB_W'($urandom), BYTE_W'($urandom)));
  endtask

  // field extremes and every special case, on a 16 x 12 screen
  task automatic directed_checks();
    queue_cmd(mk_cmd(CMD_FILL, -2048, 2047, 2047, -2048, 24'hFFFFFF, 8'h00));
    queue_cmd(mk_cmd(CMD_FILL, 3, 3, 3, 3, 24'hA5C3E7, 8'hFF));
    queue_cmd(mk_cmd(CMD_FILL, 10, 9, 2, 1, 24'h000000, 8'h00));
    queue_cmd(mk_cmd(CMD_FILL, -5, 100, 20, -30, 24'h123456, 8'h00));
    queue_cmd(mk_cmd(CMD_WRITE, 0, 0, 0, 0, 24'h0, 8'hFF));
    queue_cmd(mk_cmd(CMD_WRITE, 15, 11, 0, 0, 24'h0, 8'h00));
    queue_cmd(mk_cmd(CMD_WRITE, 16, 0, 0, 0, 24'h0, 8'h5A));
    queue_cmd(mk_cmd(CMD_WRITE, -1, 0, 0, 0, 24'h0, 8'h5A));
    queue_cmd(mk_cmd(CMD_WRITE, 0, 12, 0, 0, 24'h0, 8'h5A));
    queue_cmd(mk_cmd(CMD_WRITE, -2048, -2048, 0, 0, 24'h0, 8'h81));
    queue_cmd(mk_cmd(CMD_WRITE, 2047, 2047, 0, 0, 24'h0, 8'h7E));
    queue_cmd(mk_cmd(CMD_WRITE, 5, 7, 0, 0, 24'h0, 8'hAA));
    queue_cmd(mk_cmd(CMD_READ, 0, 0, 0, 0, 24'h0, 8'h00));
    queue_cmd(mk_cmd(CMD_READ, 15, 11, 0, 0, 24'h0, 8'h00));
    queue_cmd(mk_cmd(CMD_READ, -2048, -2048, 0, 0, 24'h0, 8'h00));
    queue_cmd(mk_cmd(CMD_READ, 2047, 2047, 0, 0, 24'h0, 8'h00));
    queue_cmd(mk_cmd(CMD_READ, 5, 7, 0, 0, 24'h0, 8'h00));
    queue_cmd(mk_cmd(CMD_READ, 3, 3, 0, 0, 24'h0, 8'h00));
    queue_cmd(mk_cmd(CMD_READ, -1, 2047, 0, 0, 24'h0, 8'h00));
    queue_cmd(mk_cmd(CMD_COLLECT, 0, 0, 0, 0, 24'h0, 8'h00));
    queue_cmd(mk_cmd(CMD_COLLECT, 0, 0, 0, 0, 24'h0, 8'h00));
    queue_cmd(mk_cmd(CMD_WRITE, 2, 2, 0, 0, 24'h0, 8'h3C));
    queue_cmd(mk_cmd(CMD_COLLECT, 0, 0, 0, 0, 24'h0, 8'h00));
  endtask

  // apb write: setup cycle, then access cycle; lands on the edge with penable high
  task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WIDTH:  geo_w   = val[COORD_W-1:0];
      REG_HEIGHT: geo_h   = val[COORD_W-1:0];
      default:    geo_off = val[OFF_W-1:0];
    endcase
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned off);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_OFFSET, off);
  endtask

  // every beat gets its result, so idle means all taken and all answered;
  // the task then waits on to cover the back end settling
  task automatic wait_idle();
    while (took_cnt != sent_cnt || pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic run_phase(int n);
    seed_corners();
    repeat (n) make_random();
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // sequence of phases: geometry only changes while the block is idle
  // ---------------------------------------------------------------------------
  initial begin : run_ctrl
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry, 480 x 320 with no offset
    run_phase(150);
    // small screen with an offset for the directed beats
    set_geometry(16, 12, 5);
    directed_checks();
    run_phase(200);
    // one pixel screens, the second from zero sizes
    set_geometry(1, 1, 0);
    run_phase(100);
    set_geometry(0, 0, 0);
    run_phase(60);
    // full store, largest offset
    set_geometry(512, 512, 511);
    run_phase(250);
    // sizes above the store limit act as the limit
    set_geometry(1023, 1023, 300);
    run_phase(200);
    // offset well past the height wraps
    set_geometry(100, 37, 300);
    run_phase(250);
    set_geometry(7, 300, 299);
    run_phase(200);
    set_geometry(300, 7, 6);
    run_phase(200);
    // last stretch runs flat out on both sides
    calm = 1'b1;
    set_geometry(480, 320, 17);
    run_phase(240);

    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // input driver: offers the backlog, holding each beat until it is taken
  // ---------------------------------------------------------------------------
  int feed_gap = 0, feed_run = 0;

  always @(negedge clk) begin : cmd_driver
    logic    nxt_valid;
    rfb_in_t nxt_data;
    nxt_valid = in_valid && !in_taken;
    nxt_data  = in_data;
    if (rst_n && !nxt_valid) begin
      if (feed_gap > 0) begin
        feed_gap--;
      end else if (cmd_backlog.size() != 0) begin
        // random idle burst, then a run with no idling
        if (!calm && feed_run == 0 && $urandom_range(0, 3) == 0) begin
          feed_gap = $urandom_range(0, 3);
          feed_run = $urandom_range(0, 24);
        end else begin
          if (feed_run > 0) feed_run--;
          nxt_valid = 1'b1;
          nxt_data  = cmd_backlog.pop_front();
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // ---------------------------------------------------------------------------
  // result sink: random stalls, plus two long hold-offs that back up the queue
  // ---------------------------------------------------------------------------
  int sink_gap = 0, sink_run = 0, hold_left = 0, holds_done = 0;

  always @(negedge clk) begin : result_sink
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if ((holds_done == 0 && seen_cnt >= 200) ||
                 (holds_done == 1 && seen_cnt >= 1100)) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ready <= 1'b0;
    end else if (!calm && sink_run == 0 && $urandom_range(0, 3) == 0) begin
      sink_gap = $urandom_range(0, 3);
      sink_run = $urandom_range(0, 24);
      out_ready <= 1'b0;
    end else begin
      if (sink_run > 0) sink_run--;
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on each input beat, checks each result beat in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : beat_monitor
    rfb_out_t want;
    in_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      pending_results.push_back(frame_result(in_data));
      took_cnt++;
    end
    if (rst_n && out_valid && out_ready) begin
      seen_cnt++;
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t ns: result beat with nothing expected, actual %0h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        check_field("read_byte",  32'(want.read_byte),  32'(out_data.read_byte));
        check_field("red_out",    32'(want.red_out),    32'(out_data.red_out));
        check_field("green_out",  32'(want.green_out),  32'(out_data.green_out));
        check_field("blue_out",   32'(want.blue_out),   32'(out_data.blue_out));
        check_field("box_valid",  32'(want.box_valid),  32'(out_data.box_valid));
        check_field("box_x_low",  32'(want.box_x_low),  32'(out_data.box_x_low));
        check_field("box_y_low",  32'(want.box_y_low),  32'(out_data.box_y_low));
        check_field("box_x_high", 32'(want.box_x_high), 32'(out_data.box_x_high));
        check_field("box_y_high", 32'(want.box_y_high), 32'(out_data.box_y_high));
        check_field("dropped",    32'(want.dropped),    32'(out_data.dropped));
      end
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
